/* rtl/core/ipv4_prefix_acl_first_match_macros.svh */
// assertion macros for the ipv4 prefix acl block
// used by the datapath; relies on aclk and aresetn being in scope
`ifndef IPV4_PREFIX_ACL_FIRST_MATCH_MACROS_SVH
`define IPV4_PREFIX_ACL_FIRST_MATCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define IPACL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IPACL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ipacl_pkg.sv */
// shared types and constants for the ipv4 prefix acl block
// no dependencies
package ipacl_pkg;

    localparam int unsigned ADDR_BITS = 32;
    localparam logic [5:0]  LEN_MAX   = 6'd32;
    localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        KIND_STORED  = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_ANSWER  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // one stored rule
    typedef struct packed {
        logic [ADDR_BITS-1:0] prefix;
        logic [5:0]           length;
        logic                 verdict;
    } rule_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the accepted transaction
        logic add_en;    // append rule or flag table full
        logic scan_en;   // walk the rule memory
        logic emit;      // result handed to the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic hit;
        logic last;
    } stat_t;

    typedef struct packed {
        kind_t      kind;
        logic       permit;
        logic       matched;
        logic [5:0] index;
    } res_t;

    function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [5:0] len);
        logic [5:0] sh;
        sh = LEN_MAX - len;
        if (len == '0) begin
            return '0;
        end
        return ADDR_ONES << sh;
    endfunction

endpackage

/* rtl/core/ipv4_prefix_acl_first_match.sv */
// top level of the first-match ipv4 prefix access list
// depends on ipacl_pkg, ipacl_ctrl and ipacl_dp
//
// channel   dir  tdata (lsb first)                        tuser
// s_        in   address[31:0] prefix_len[37:32] allow[38] action (0 add, 1 query)
// m_        out  permit[0] matched[1] rule_index[7:2]      kind (0 stored, 1 dropped, 2 answer)
//
// an add holds the block through capture, memory write and hand-off
// a query walks the rules up to and including the first match, all of them on a miss
// and at most MAX_RULES: the rule memory has one read port and is walked one entry per
// cycle behind a registered read; a query on an empty table skips the walk
// one transaction is in flight at a time; a waiting result sits in the output register
// while the next transaction is accepted and worked on, a full output register stalls
// only the hand-off; synchronous active-low reset empties the table, no clearing pass
module ipv4_prefix_acl_first_match #(
    parameter int unsigned MAX_RULES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // address, prefix_len, allow, zero pad
    input  logic        s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // permit, matched, rule_index
    output logic [1:0]  m_tuser     // kind
);
    import ipacl_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    res_t  res;
    logic  out_free;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;

    // output slot can take a result this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    ipacl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd)
    );

    ipacl_dp #(
        .MAX_RULES (MAX_RULES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_address    (s_tdata[31:0]),
        .in_prefix_len (s_tdata[37:32]),
        .in_allow      (s_tdata[38]),
        .cmd           (cmd),
        .stat          (stat),
        .res           (res)
    );

    // output register, decouples result hand-off from the next transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {res.index, res.matched, res.permit};
            m_tuser_reg <= res.kind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/core/ipacl_ctrl.sv */
// sequencing state machine for the ipv4 prefix acl block
// depends on ipacl_pkg
module ipacl_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            in_action,
    output logic            in_ready,
    input  logic            out_free,
    input  ipacl_pkg::stat_t stat,
    output ipacl_pkg::cmd_t  cmd
);
    import ipacl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (in_action == ACT_ADD) begin
                        state_next = ST_ADD;
                    end else if (stat.count_zero) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_ADD: begin
                cmd.add_en = 1'b1;
                state_next = ST_RESULT;
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.hit || stat.last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ipacl_dp.sv */
// rule memory, scan pipeline and result registers for the ipv4 prefix acl block
// depends on ipacl_pkg and ipv4_prefix_acl_first_match_macros.svh
module ipacl_dp #(
    parameter int unsigned MAX_RULES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          in_address,
    input  logic [5:0]           in_prefix_len,
    input  logic                 in_allow,
    input  ipacl_pkg::cmd_t      cmd,
    output ipacl_pkg::stat_t     stat,
    output ipacl_pkg::res_t      res
);
    import ipacl_pkg::*;
    `include "ipv4_prefix_acl_first_match_macros.svh"

    localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RULES);

    rule_t mem [MAX_RULES];

    logic [31:0]      addr_reg;
    logic [5:0]       len_reg;
    logic             allow_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    rule_t            rdata_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    res_t             res_reg;

    logic             full;
    logic             wr_en;
    logic             issue;
    logic [31:0]      cmp_mask;
    logic             hit;
    logic             last;

    assign full     = (count_reg == CNT_MAX);
    assign wr_en    = cmd.add_en && !full;
    assign issue    = cmd.scan_en && (rd_idx_reg < count_reg);
    assign cmp_mask = prefix_mask(rdata_reg.length);
    assign hit      = cmp_valid_reg && ((addr_reg & cmp_mask) == rdata_reg.prefix);
    assign last     = cmp_valid_reg
                      && ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);

    assign stat.count_zero = (count_reg == '0);
    assign stat.hit        = hit;
    assign stat.last       = last;
    assign res             = res_reg;

    // rule memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= '{prefix:  addr_reg & prefix_mask(len_reg),
                                           length:  len_reg,
                                           verdict: allow_reg};
        end
        rdata_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    // captured transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg  <= in_address;
            len_reg   <= (in_prefix_len > LEN_MAX) ? LEN_MAX : in_prefix_len;
            allow_reg <= in_allow;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
        end else begin
            if (wr_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.load) begin
                rd_idx_reg    <= '0;
                cmp_valid_reg <= 1'b0;
            end else begin
                cmp_valid_reg <= issue;
                cmp_idx_reg   <= rd_idx_reg[IDX_W-1:0];
                if (issue) begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end
        end
    end

    // result: an add reports stored or dropped; a query defaults to allow with no match until a rule hits
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_reg <= '{kind: KIND_ANSWER, permit: 1'b1, matched: 1'b0, index: '0};
        end else if (cmd.add_en) begin
            res_reg <= '{kind: (full ? KIND_DROPPED : KIND_STORED),
                         permit: 1'b0, matched: 1'b0, index: '0};
        end else if (cmd.scan_en && hit) begin
            res_reg.permit  <= rdata_reg.verdict;
            res_reg.matched <= 1'b1;
            res_reg.index   <= 6'(cmp_idx_reg);
        end
    end

    `IPACL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_MAX, "rule count above table size")
    `IPACL_ASSERT_IMP(a_hit_in_range, cmd.scan_en && hit, CNT_W'(cmp_idx_reg) < count_reg, "hit on unwritten rule")
    `IPACL_ASSERT_NXT(a_add_grows, wr_en, count_reg == $past(count_reg) + CNT_W'(1), "add did not grow table")
    `IPACL_ASSERT_NXT(a_load_flush, cmd.load, !cmp_valid_reg && (rd_idx_reg == '0), "scan pipe not flushed")

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the first-match ipv4 prefix access list
// needs ipacl_pkg and ipv4_prefix_acl_first_match with its ipacl_ctrl and ipacl_dp
module tb;
    import ipacl_pkg::*;

    localparam int TABLE_DEPTH      = 64;
    localparam int RANDOM_PER_PHASE = 250;
    // outlasts the longest query walk over TABLE_DEPTH rules, with some slack
    localparam int DRAIN_CYCLES     = 80;
    // ~800 transactions, each up to a full table walk plus sender and receiver
    // stalls; keep a wide margin
    localparam int CYCLE_LIMIT      = 400000;

    // one input transaction as the bench sees it
    typedef struct packed {
        logic        action;
        logic [31:0] addr;
        logic [5:0]  len;
        logic        allow;
    } acl_req_t;

    // one result transaction
    typedef struct packed {
        kind_t      kind;
        logic       permit;
        logic       matched;
        logic [5:0] index;
    } acl_resp_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // address, prefix_len, allow, zero pad
    logic        s_tuser  = 1'b0; // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // permit, matched, rule_index
    logic [1:0]  m_tuser;         // kind

    // transactions waiting to be driven, and verdicts waiting to come back
    acl_req_t  req_q[$];
    acl_resp_t verdict_q[$];
    acl_req_t  drv_req;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_errors      = 0;
    int n_cycles      = 0;

    // predictor copy of the rule table
    logic [31:0] acl_prefix  [TABLE_DEPTH];
    logic [5:0]  acl_len     [TABLE_DEPTH];
    logic        acl_verdict [TABLE_DEPTH];
    int          acl_count;

    // rules as generated, used to aim queries at stored prefixes and to pick duplicate adds
    logic [31:0] aim_addr[$];
    logic [5:0]  aim_len[$];

    ipv4_prefix_acl_first_match #(
        .MAX_RULES(TABLE_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // network mask for a prefix length, lengths above 32 behave as 32
    function automatic logic [31:0] cover_mask(input logic [5:0] len);
        int n;
        n = (len > LEN_MAX) ? 32 : int'(len);
        if (n == 0) begin
            return '0;
        end
        return 32'hFFFF_FFFF << (32 - n);
    endfunction

    // apply one accepted transaction to the predictor table, return its verdict
    function automatic acl_resp_t apply_acl_request(input acl_req_t req);
        acl_resp_t  r;
        logic [5:0] len;
        r.kind    = KIND_STORED;
        r.permit  = 1'b0;
        r.matched = 1'b0;
        r.index   = '0;
        if (req.action == ACT_ADD) begin
            if (acl_count < TABLE_DEPTH) begin
                len = (req.len > LEN_MAX) ? LEN_MAX : req.len;
                acl_prefix[acl_count]  = req.addr & cover_mask(len);
                acl_len[acl_count]     = len;
                acl_verdict[acl_count] = req.allow;
                acl_count++;
            end else begin
                r.kind = KIND_DROPPED;
            end
        end else begin
            // default allow unless an earlier rule covers the address
            r.kind   = KIND_ANSWER;
            r.permit = 1'b1;
            for (int i = 0; i < acl_count; i++) begin
                if ((req.addr & cover_mask(acl_len[i])) == acl_prefix[i]) begin
                    r.permit  = acl_verdict[i];
                    r.matched = 1'b1;
                    r.index   = 6'(i);
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", n_cycles, msg);
        n_errors++;
    endtask

    task automatic push_add(input logic [31:0] addr, input logic [5:0] len,
                            input logic allow);
        acl_req_t req;
        req.action = ACT_ADD;
        req.addr   = addr;
        req.len    = len;
        req.allow  = allow;
        req_q.push_back(req);
        if (aim_addr.size() < TABLE_DEPTH) begin
            aim_addr.push_back(addr);
            aim_len.push_back((len > LEN_MAX) ? LEN_MAX : len);
        end
    endtask

    // prefix_len and allow carry noise on a query, the block must ignore them
    task automatic push_query(input logic [31:0] addr);
        acl_req_t req;
        req.action = ACT_QUERY;
        req.addr   = addr;
        req.len    = 6'($urandom_range(63));
        req.allow  = 1'($urandom_range(1));
        req_q.push_back(req);
    endtask

    // mostly queries aimed at stored rules, some near misses and plain noise,
    // the rest adds; the last two table entries get the widest prefixes so
    // that misses stay possible until the table is full
    task automatic push_random(input int n);
        int          pick;
        int          j;
        int          bitpos;
        logic [31:0] a;
        logic [31:0] m;
        logic [5:0]  len;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                if (aim_addr.size() == TABLE_DEPTH - 2) begin
                    push_add($urandom(), 6'd1, 1'($urandom_range(1)));
                end else if (aim_addr.size() == TABLE_DEPTH - 1) begin
                    push_add($urandom(), 6'd0, 1'($urandom_range(1)));
                end else if (pick < 2 && aim_addr.size() != 0) begin
                    // duplicate of an earlier rule, can never win
                    j = $urandom_range(aim_addr.size() - 1);
                    push_add(aim_addr[j], aim_len[j], 1'($urandom_range(1)));
                end else begin
                    j = $urandom_range(99);
                    if (j < 70) begin
                        len = 6'($urandom_range(32, 12));
                    end else if (j < 85) begin
                        len = 6'($urandom_range(63, 33));
                    end else begin
                        len = 6'($urandom_range(11, 2));
                    end
                    push_add($urandom(), len, 1'($urandom_range(1)));
                end
            end else begin
                j = $urandom_range(aim_addr.size() - 1);
                m = cover_mask(aim_len[j]);
                a = (aim_addr[j] & m) | ($urandom() & ~m);
                if (pick < 70) begin
                    push_query(a);
                end else if (pick < 85 && aim_len[j] != 0) begin
                    // flip one network bit for a near miss
                    bitpos = 31 - $urandom_range(int'(aim_len[j]) - 1);
                    push_query(a ^ (32'h1 << bitpos));
                end else begin
                    push_query($urandom());
                end
            end
        end
    endtask

    // sender holds off until every transaction has come back
    task automatic wait_drained;
        while (req_q.size() != 0 || s_tvalid || verdict_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // driver: predicts on acceptance, then offers the next pending transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            acl_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                verdict_q.push_back(apply_acl_request(drv_req));
            end
            if (!s_tvalid || s_tready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, drv_req.allow, drv_req.len, drv_req.addr};
                    s_tuser  <= drv_req.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, each accepted result against the oldest verdict
    always @(posedge aclk) begin : result_check
        acl_resp_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d data %02h",
                                          m_tuser, m_tdata));
            end else begin
                want = verdict_q.pop_front();
                if (m_tuser !== want.kind) begin
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              m_tuser, want.kind));
                end
                if (m_tdata[0] !== want.permit) begin
                    report_mismatch($sformatf("permit %0b, expected %0b",
                                              m_tdata[0], want.permit));
                end
                if (m_tdata[1] !== want.matched) begin
                    report_mismatch($sformatf("matched %0b, expected %0b",
                                              m_tdata[1], want.matched));
                end
                if (m_tdata[7:2] !== want.index) begin
                    report_mismatch($sformatf("rule_index %0d, expected %0d",
                                              m_tdata[7:2], want.index));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // phase one: sender mostly busy, receiver mostly stalling
        @(negedge aclk);
        send_idle_pct = 21;
        recv_idle_pct = 75;

        // lookups on an empty table fall through to allow
        push_query(32'h0000_0000);
        push_query(32'hFFFF_FFFF);
        // host route at the top of the space
        push_add(32'hFFFF_FFFF, 6'd32, 1'b0);
        push_query(32'hFFFF_FFFF);
        push_query(32'hFFFF_FFFE);
        // host bits in a rule address are masked off when stored
        push_add(32'h0A12_3456, 6'd8, 1'b1);
        push_query(32'h0AFF_FFFF);
        // more specific rule behind a wider one is shadowed
        push_add(32'h0A12_0000, 6'd16, 1'b0);
        push_query(32'h0A12_0001);
        push_query(32'h0B12_0001);
        // duplicate with the opposite verdict never wins
        push_add(32'hFFFF_FFFF, 6'd32, 1'b1);
        push_query(32'hFFFF_FFFF);
        // oversize prefix lengths saturate to an exact match
        push_add(32'hC0A8_0101, 6'd63, 1'b0);
        push_query(32'hC0A8_0101);
        push_query(32'hC0A8_0100);
        push_add(32'h1234_5678, 6'd33, 1'b1);
        push_query(32'h1234_5678);
        // host route at the bottom of the space
        push_add(32'h0000_0000, 6'd32, 1'b1);
        push_query(32'h0000_0000);
        push_query(32'h7FFF_FFFF);

        push_random(RANDOM_PER_PHASE);
        wait_drained();

        // phase two: roles swapped
        @(negedge aclk);
        send_idle_pct = 75;
        recv_idle_pct = 21;
        push_random(RANDOM_PER_PHASE);
        wait_drained();

        // phase three: full throughput, table full so adds are dropped
        @(negedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(RANDOM_PER_PHASE);
        wait_drained();

        // anything stray would show up here
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
